FILE: rtl/core/scoped_symbol_table_top_defines.svh
// Assertion macros for the scoped symbol table.
// Included by the top level; no other dependencies.
`ifndef SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted (active low).
`define SST_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sst assertion failed");
// Next-cycle implication, disabled while reset is asserted (active low).
`define SST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sst assertion failed");
`else
`define SST_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define SST_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/sst_pkg.sv
// Shared types and constants of the scoped symbol table.
// No dependencies; compiled first.
package sst_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned MarkW        = IdxW + 1;
  localparam int unsigned SlotW        = 8;
  localparam int unsigned MarkFieldW   = 9;

  localparam logic [15:0] FnPayload = 16'h00FF;
  localparam logic [15:0] DepthMax  = 16'hFFFF;

  localparam logic [2:0] ClsFunc  = 3'd0;
  localparam logic [2:0] ClsProto = 3'd1;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_ADD_G  = 3'd1,
    OP_ADD_L  = 3'd2,
    OP_UPDATE = 3'd3,
    OP_PUSH   = 3'd4,
    OP_POP    = 3'd5,
    OP_SET_G  = 3'd6,
    OP_NOP    = 3'd7
  } sst_op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        name_id;
    logic [2:0]         sym_kind;
    logic [7:0]         type_id;
    logic signed [15:0] value;
    logic               scope_local;
    logic [7:0]         flags;
    logic [8:0]         frame_mark;
    logic [8:0]         global_count_to;
  } sst_in_t;

  typedef struct packed {
    logic               found;
    logic               table_full;
    logic [7:0]         slot;
    logic [2:0]         out_class;
    logic [7:0]         out_type;
    logic               out_scope;
    logic [7:0]         out_flags;
    logic signed [15:0] out_payload;
    logic [8:0]         local_mark;
    logic [8:0]         global_count;
    logic               in_scope;
  } sst_out_t;

  typedef struct packed {
    logic [15:0] name;
    logic [2:0]  cls;
    logic [7:0]  typ;
    logic        scope;
    logic [7:0]  flags;
    logic [15:0] payload;
  } sst_entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_local;
    logic alloc_g;
    logic alloc_l;
    logic wr_update;
    logic set_full;
    logic push;
    logic pop;
    logic set_gcount;
    logic out_load;
  } sst_cmd_t;

  typedef struct packed {
    logic    scan_done;
    logic    scan_hit;
    logic    full;
    sst_op_e op;
    logic    scope_local;
  } sst_sts_t;

endpackage

FILE: rtl/core/sst_in_if.sv
// Input channel of the scoped symbol table: valid, ready and one item.
// Depends on sst_pkg.
interface sst_in_if;
  import sst_pkg::*;

  logic    valid;
  logic    ready;
  sst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/sst_out_if.sv
// Result channel of the scoped symbol table: valid, ready and one result.
// Depends on sst_pkg.
interface sst_out_if;
  import sst_pkg::*;

  logic     valid;
  logic     ready;
  sst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/scoped_symbol_table_top.sv
// Scoped symbol table: one item in, one result out per item.
// The block takes one item at a time on in_i (valid/ready). Each beat carries an
// opcode: lookup, add global, add local, update, push frame, pop frame, set
// global count, or no-op. Every item yields exactly one result beat on out_o.
// Storage is one entry store of sst_pkg::TableEntries slots: globals grow up from
// slot 0, locals grow down from the top. Searches read one entry per cycle from
// the store and compare the name in the cycle after the read. Frame, count and
// no-op items skip the search and pass through the execute and result states.
// A lookup may scan locals and then globals, all through the single read port
// of the entry store. After a count set or a pop that makes the two ranges
// overlap, a missed lookup scans the shared slots in both searches.
// The block works on one item at a time.
// The result sits in an output register: the next item is accepted while a
// finished result waits, and a stalled receiver only holds the block once the
// following result is ready to be handed off.
// Reset clears the marks (no globals, no locals) and the scope depth; the entry
// store is not cleared and needs no clearing pass.
`include "scoped_symbol_table_top_defines.svh"

module scoped_symbol_table_top (
  input logic  clk_i,
  input logic  rst_ni,
  sst_in_if.sink    in_i,
  sst_out_if.source out_o
);
  import sst_pkg::*;

  sst_cmd_t cmd;
  sst_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Controller: one-hot sequencer for the item in flight and the result beat.
  sst_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_op_i          (in_i.data.opcode),
    .in_scope_local_i (in_i.data.scope_local),
    .in_ready_o       (in_ready),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_valid),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  // Datapath: entry store, scan unit, marks and result register.
  sst_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // One item in flight: an accepted beat closes the input until its result is out.
  `SST_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // Never allocate into an exhausted store.
  `SST_ASSERT_NOW(a_alloc_not_full, clk_i, rst_ni, cmd.alloc_g || cmd.alloc_l, !sts.full)
  // A refused add never reports an entry.
  `SST_ASSERT_NOW(a_full_no_entry, clk_i, rst_ni, out_o.valid && out_o.data.table_full,
                  !out_o.data.found)

endmodule

FILE: rtl/core/sst_dpath.sv
// Datapath: entry store, scan unit, marks, depth counter and result register.
// Depends on sst_pkg; driven by sst_ctrl through sst_cmd_t.
module sst_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sst_pkg::sst_in_t  in_data_i,
  input  sst_pkg::sst_cmd_t cmd_i,
  output sst_pkg::sst_sts_t sts_o,
  output sst_pkg::sst_out_t out_data_o
);
  import sst_pkg::*;

  sst_entry_t mem_q [TableEntries];

  sst_in_t    item_q;
  logic [MarkW-1:0] gtop_q, gtop_d;
  logic [MarkW-1:0] lbot_q, lbot_d;
  logic [15:0]      depth_q, depth_d;

  logic             scan_act_q, scan_act_d;
  logic [MarkW-1:0] ptr_q, ptr_d;
  logic [MarkW-1:0] end_q, end_d;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  sst_entry_t       rd_data_q;

  logic             res_found_q, res_full_q;
  logic [IdxW-1:0]  res_idx_q;
  sst_entry_t       res_ent_q;
  sst_out_t         out_q;

  logic             match, more, issue, scan_done;
  logic [MarkW-1:0] lbot_dec;
  sst_entry_t       new_ent, upd_ent, wr_data;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;

  // Scan: one read per cycle, compare in the cycle after the read.
  assign match     = rd_vld_q && (rd_data_q.name == item_q.name_id);
  assign more      = ptr_q < end_q;
  assign issue     = scan_act_q && more && !match;
  assign scan_done = scan_act_q && (match || (!rd_vld_q && !more));

  assign lbot_dec = lbot_q - MarkW'(1);

  always_comb begin
    new_ent.name    = item_q.name_id;
    new_ent.cls     = item_q.sym_kind;
    new_ent.typ     = item_q.type_id;
    new_ent.scope   = cmd_i.alloc_l;
    new_ent.flags   = '0;
    new_ent.payload = (item_q.sym_kind == ClsFunc || item_q.sym_kind == ClsProto)
                      ? FnPayload : item_q.value;

    upd_ent.name    = item_q.name_id;
    upd_ent.cls     = item_q.sym_kind;
    upd_ent.typ     = item_q.type_id;
    upd_ent.scope   = item_q.scope_local;
    upd_ent.flags   = item_q.flags;
    upd_ent.payload = item_q.value;
  end

  assign wr_en   = cmd_i.alloc_g || cmd_i.alloc_l || cmd_i.wr_update;
  assign wr_data = cmd_i.wr_update ? upd_ent : new_ent;

  always_comb begin
    if (cmd_i.alloc_g) begin
      wr_addr = gtop_q[IdxW-1:0];
    end else if (cmd_i.alloc_l) begin
      wr_addr = lbot_dec[IdxW-1:0];
    end else begin
      wr_addr = res_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= mem_q[ptr_q[IdxW-1:0]];
      rd_idx_q  <= ptr_q[IdxW-1:0];
    end
  end

  // Scan control and marks.
  always_comb begin
    scan_act_d = scan_act_q;
    ptr_d      = ptr_q;
    end_d      = end_q;
    gtop_d     = gtop_q;
    lbot_d     = lbot_q;
    depth_d    = depth_q;

    if (scan_done) begin
      scan_act_d = 1'b0;
    end
    if (issue) begin
      ptr_d = ptr_q + MarkW'(1);
    end
    if (cmd_i.scan_start) begin
      scan_act_d = 1'b1;
      ptr_d      = cmd_i.scan_local ? lbot_q : '0;
      end_d      = cmd_i.scan_local ? MarkW'(TableEntries) : gtop_q;
    end

    if (cmd_i.alloc_g) begin
      gtop_d = gtop_q + MarkW'(1);
    end
    if (cmd_i.alloc_l) begin
      lbot_d = lbot_dec;
    end
    if (cmd_i.push && depth_q != DepthMax) begin
      depth_d = depth_q + 16'd1;
    end
    if (cmd_i.pop) begin
      lbot_d = (32'(item_q.frame_mark) > TableEntries) ? MarkW'(TableEntries)
                                                     : MarkW'(item_q.frame_mark);
      if (depth_q != 16'd0) begin
        depth_d = depth_q - 16'd1;
      end
    end
    if (cmd_i.set_gcount) begin
      gtop_d = (32'(item_q.global_count_to) > TableEntries) ? MarkW'(TableEntries)
                                                          : MarkW'(item_q.global_count_to);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      ptr_q      <= '0;
      end_q      <= '0;
      gtop_q     <= '0;
      lbot_q     <= MarkW'(TableEntries);
      depth_q    <= '0;
    end else begin
      scan_act_q <= scan_act_d;
      rd_vld_q   <= issue;
      ptr_q      <= ptr_d;
      end_q      <= end_d;
      gtop_q     <= gtop_d;
      lbot_q     <= lbot_d;
      depth_q    <= depth_d;
    end
  end

  // Item latch and result assembly.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q      <= in_data_i;
      res_found_q <= 1'b0;
      res_full_q  <= 1'b0;
      res_idx_q   <= '0;
      res_ent_q   <= '0;
    end else begin
      if (scan_done && match) begin
        res_found_q <= 1'b1;
        res_idx_q   <= rd_idx_q;
        res_ent_q   <= rd_data_q;
      end
      if (cmd_i.alloc_g || cmd_i.alloc_l) begin
        res_found_q <= 1'b1;
        res_idx_q   <= wr_addr;
        res_ent_q   <= new_ent;
      end
      if (cmd_i.wr_update) begin
        res_ent_q <= upd_ent;
      end
      if (cmd_i.set_full) begin
        res_full_q <= 1'b1;
      end
    end

    if (cmd_i.out_load) begin
      out_q.found        <= res_found_q;
      out_q.table_full   <= res_full_q;
      out_q.slot         <= SlotW'(res_idx_q);
      out_q.out_class    <= res_ent_q.cls;
      out_q.out_type     <= res_ent_q.typ;
      out_q.out_scope    <= res_ent_q.scope;
      out_q.out_flags    <= res_ent_q.flags;
      out_q.out_payload  <= $signed(res_ent_q.payload);
      out_q.local_mark   <= MarkFieldW'(lbot_q);
      out_q.global_count <= MarkFieldW'(gtop_q);
      out_q.in_scope     <= (depth_q != 16'd0);
    end
  end

  assign out_data_o = out_q;

  assign sts_o.scan_done   = scan_done;
  assign sts_o.scan_hit    = match;
  assign sts_o.full        = gtop_q >= lbot_q;
  assign sts_o.op          = sst_op_e'(item_q.opcode);
  assign sts_o.scope_local = item_q.scope_local;

endmodule

FILE: rtl/core/sst_ctrl.sv
// Controller: sequences scans, writes and result hand-off per item.
// Depends on sst_pkg; drives sst_dpath through sst_cmd_t.
module sst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_op_i,
  input  logic              in_scope_local_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  sst_pkg::sst_sts_t sts_i,
  output sst_pkg::sst_cmd_t cmd_o
);
  import sst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_SCAN2 = 5'b00100,
    S_EXEC  = 5'b01000,
    S_RESP  = 5'b10000
  } sst_state_e;

  sst_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;
  sst_op_e    in_op;

  assign in_op      = sst_op_e'(in_op_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (in_op)
            OP_LOOKUP, OP_ADD_L: begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_local = 1'b1;
              state_d          = S_SCAN1;
            end
            OP_ADD_G: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN1;
            end
            OP_UPDATE: begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_local = in_scope_local_i;
              state_d          = S_SCAN1;
            end
            default: state_d = S_EXEC;
          endcase
        end
      end
      S_SCAN1: begin
        if (sts_i.scan_done) begin
          if (sts_i.scan_hit) begin
            state_d = (sts_i.op == OP_UPDATE) ? S_EXEC : S_RESP;
          end else begin
            case (sts_i.op)
              OP_LOOKUP: begin
                // Locals missed: fall back to the globals.
                cmd_o.scan_start = 1'b1;
                state_d          = S_SCAN2;
              end
              OP_ADD_G, OP_ADD_L: state_d = S_EXEC;
              default:            state_d = S_RESP;
            endcase
          end
        end
      end
      S_SCAN2: begin
        if (sts_i.scan_done) begin
          state_d = S_RESP;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_ADD_G: begin
            cmd_o.set_full = sts_i.full;
            cmd_o.alloc_g  = !sts_i.full;
          end
          OP_ADD_L: begin
            cmd_o.set_full = sts_i.full;
            cmd_o.alloc_l  = !sts_i.full;
          end
          OP_UPDATE: cmd_o.wr_update  = 1'b1;
          OP_PUSH:   cmd_o.push       = 1'b1;
          OP_POP:    cmd_o.pop        = 1'b1;
          OP_SET_G:  cmd_o.set_gcount = 1'b1;
          default:   cmd_o.push       = 1'b0;
        endcase
        state_d = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free.
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
